### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds define SYNTHESIS, which
// turns every use into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/crcc_pkg.sv
`timescale 1ns / 1ps

package crcc_pkg;

    localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SEED_VALUE        = 3'd0,
        REG_INPUT_COMPLEMENT  = 3'd1,
        REG_INPUT_REFLECT     = 3'd2,
        REG_OUTPUT_COMPLEMENT = 3'd3,
        REG_OUTPUT_REFLECT    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] seed_value;
        logic        input_complement;
        logic        input_reflect;
        logic        output_complement;
        logic        output_reflect;
    } cfg_t;

    // One prepared message byte waiting for the CRC engine.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [31:0] rev32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
        begin
            r[i] = v[31-i];
        end
        return r;
    endfunction

    // Eight MSB-first shifts of the CRC register, unrolled into XOR logic.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] din);
        logic [31:0] c;
        logic        fb;
        c = crc_in;
        for (int b = 7; b >= 0; b--)
        begin
            fb = c[31] ^ din[b];
            c  = {c[30:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

### rtl/crcc_front.sv
`timescale 1ns / 1ps

module crcc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [crcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]                    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tlast,
    input  crcc_pkg::q_status_t            q_status,
    output logic                           push,
    output crcc_pkg::item_t                push_item,
    output crcc_pkg::cfg_t                 cfg
);

    crcc_pkg::cfg_t cfg_reg;
    crcc_pkg::cfg_t cfg_next;
    logic [7:0]     byte_c;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (crcc_pkg::cfg_index_t'(cfg_addr))
                crcc_pkg::REG_SEED_VALUE:        cfg_next.seed_value        = cfg_wdata;
                crcc_pkg::REG_INPUT_COMPLEMENT:  cfg_next.input_complement  = cfg_wdata[0];
                crcc_pkg::REG_INPUT_REFLECT:     cfg_next.input_reflect     = cfg_wdata[0];
                crcc_pkg::REG_OUTPUT_COMPLEMENT: cfg_next.output_complement = cfg_wdata[0];
                crcc_pkg::REG_OUTPUT_REFLECT:    cfg_next.output_reflect    = cfg_wdata[0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed_value        <= crcc_pkg::CRC_ALL_ONES;
            cfg_reg.input_complement  <= 1'b0;
            cfg_reg.input_reflect     <= 1'b0;
            cfg_reg.output_complement <= 1'b0;
            cfg_reg.output_reflect    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Complement first, then reflect, so the queue holds bytes ready for the engine.
    always_comb
    begin
        byte_c = cfg_reg.input_complement ? ~s_tdata : s_tdata;
        if (cfg_reg.input_reflect)
        begin
            byte_c = crcc_pkg::rev8(byte_c);
        end
    end

    assign s_tready       = !q_status.full;
    assign push           = s_tvalid && !q_status.full;
    assign push_item.data = byte_c;
    assign push_item.last = s_tlast;
    assign cfg            = cfg_reg;

endmodule

### rtl/crcc_queue.sv
`timescale 1ns / 1ps

module crcc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  crcc_pkg::item_t     push_item,
    input  logic                pop,
    output crcc_pkg::item_t     head_item,
    output crcc_pkg::q_status_t q_status
);

    crcc_pkg::item_t                  entry_reg [crcc_pkg::QUEUE_DEPTH];
    logic [crcc_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [crcc_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [crcc_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [crcc_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [crcc_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [crcc_pkg::QUEUE_CNT_W-1:0] count_next;

    // The depth is a power of two, so the pointers wrap on their own.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item      = entry_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != '0);
    assign q_status.full  =
        (count_reg == crcc_pkg::QUEUE_CNT_W'(crcc_pkg::QUEUE_DEPTH));

endmodule

### rtl/crcc_back.sv
`timescale 1ns / 1ps

module crcc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  crcc_pkg::cfg_t      cfg,
    input  crcc_pkg::item_t     head_item,
    input  crcc_pkg::q_status_t q_status,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic        start_reg;
    logic        start_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_data_reg;
    logic [31:0] crc_in;
    logic [31:0] crc_upd;
    logic [31:0] crc_final;

    // A plain byte never waits; a last byte waits only for room in the output register.
    assign pop = q_status.valid && (!head_item.last || !out_valid_reg || m_tready);

    always_comb
    begin
        crc_in    = start_reg ? cfg.seed_value : crc_reg;
        crc_upd   = crcc_pkg::crc_byte(crc_in, head_item.data);
        crc_final = cfg.output_reflect ? crcc_pkg::rev32(crc_upd) : crc_upd;
        if (cfg.output_complement)
        begin
            crc_final = crc_final ^ crcc_pkg::CRC_ALL_ONES;
        end

        crc_next       = crc_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (pop)
        begin
            if (head_item.last)
            begin
                crc_next       = cfg.seed_value;
                start_next     = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                crc_next   = crc_upd;
                start_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= crcc_pkg::CRC_ALL_ONES;
            start_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_item.last)
        begin
            out_data_reg <= crc_final;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/crc32_configurable_stream.sv
// Dataflow: an accepted byte is written into the queue, the CRC engine takes it from the
// queue head, and a last byte's CRC is registered in the output register for m_tvalid.
// Throughput: one byte per cycle through the combinational CRC byte update, unless a last
// byte waits for the busy result register; the four-byte queue lets input run on meanwhile.
// Reset: rst_n empties the queue and the output register and returns the configuration
// to its defaults (seed all ones, all options off); the next byte starts a new message.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc32_configurable_stream (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [crcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]                    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata    // [31:0] crc_value
);

    crcc_pkg::cfg_t      cfg;
    crcc_pkg::item_t     push_item;
    crcc_pkg::item_t     head_item;
    crcc_pkg::q_status_t q_status;
    logic                push;
    logic                pop;

    crcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item),
        .cfg       (cfg)
    );

    crcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    crcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head_item (head_item),
        .q_status  (q_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `ASSERT_ALWAYS(a_full_not_empty, clk, rst_n, !q_status.full || q_status.valid, "full and empty")
    `ASSERT_NEXT(a_last_gives_result, clk, rst_n, pop && head_item.last, m_tvalid, "no CRC out")
    `ASSERT_NEXT(a_full_holds, clk, rst_n, q_status.full && !pop, q_status.full, "word lost")
    `ASSERT_ALWAYS(a_no_pop_empty, clk, rst_n, !pop || q_status.valid, "pop from empty queue")

endmodule
